>>> rtl/core/rbst_pkg.sv
// Shared types and constants for the ray versus box slab test.
package rbst_pkg;

  // Fixed point format of coordinates, distances and reciprocals
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int QUOT_W    = PROD_W - FRAC_BITS;
  localparam int NUM_AXES  = 3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BOX_LOW_X  = 3'd0,
    REG_BOX_LOW_Y  = 3'd1,
    REG_BOX_LOW_Z  = 3'd2,
    REG_BOX_HIGH_X = 3'd3,
    REG_BOX_HIGH_Y = 3'd4,
    REG_BOX_HIGH_Z = 3'd5
  } rbst_reg_t;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } rbst_load_t;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

>>> rtl/core/rbst_slab.sv
// One axis of the slab test: near and far distances over three stages.
module rbst_slab import rbst_pkg::*; (
  input  logic       clk,
  input  rbst_load_t load,
  input  coord_t     box_low,
  input  coord_t     box_high,
  input  coord_t     origin,
  input  coord_t     inv_dir,
  input  logic       sign,
  output coord_t     t_near,
  output coord_t     t_far
);

  logic signed [DIFF_W-1:0] diff_near;
  logic signed [DIFF_W-1:0] diff_far;
  coord_t                   inv_s1;
  logic signed [PROD_W-1:0] prod_near_full;
  logic signed [PROD_W-1:0] prod_far_full;
  logic signed [PROD_W-1:0] prod_near;
  logic signed [PROD_W-1:0] prod_far;
  coord_t                   t_near_next;
  coord_t                   t_far_next;

  // Stage 1: pick the near and far bounds by sign and subtract the origin exactly
  always_ff @(posedge clk) begin
    if (load.s1) begin
      if (sign) begin
        diff_near <= DIFF_W'(box_high) - DIFF_W'(origin);
        diff_far  <= DIFF_W'(box_low) - DIFF_W'(origin);
      end else begin
        diff_near <= DIFF_W'(box_low) - DIFF_W'(origin);
        diff_far  <= DIFF_W'(box_high) - DIFF_W'(origin);
      end
      inv_s1 <= inv_dir;
    end
  end

  // Stage 2: full products, which always fit in PROD_W signed bits
  assign prod_near_full = PROD_W'(diff_near) * PROD_W'(inv_s1);
  assign prod_far_full  = PROD_W'(diff_far) * PROD_W'(inv_s1);

  always_ff @(posedge clk) begin
    if (load.s2) begin
      prod_near <= prod_near_full;
      prod_far  <= prod_far_full;
    end
  end

  // Floor to the fraction point and clamp to the coordinate range
  function automatic coord_t floor_sat(input logic signed [PROD_W-1:0] p);
    logic [QUOT_W-1:0] q;
    logic              fits;
    coord_t            res;
    q    = p[PROD_W-1:FRAC_BITS];
    fits = (&q[QUOT_W-1:COORD_W-1]) || !(|q[QUOT_W-1:COORD_W-1]);
    if (fits) begin
      res = $signed(q[COORD_W-1:0]);
    end else if (q[QUOT_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  assign t_near_next = floor_sat(prod_near);
  assign t_far_next  = floor_sat(prod_far);

  // Stage 3: register the clamped distances
  always_ff @(posedge clk) begin
    if (load.s3) begin
      t_near <= t_near_next;
      t_far  <= t_far_next;
    end
  end

endmodule

>>> rtl/core/rbst_merge.sv
// Interval merge of the three slabs and the window test over two stages.
module rbst_merge import rbst_pkg::*; (
  input  logic       clk,
  input  rbst_load_t load,
  input  coord_t     t_near [NUM_AXES],
  input  coord_t     t_far  [NUM_AXES],
  input  coord_t     window_near,
  input  coord_t     window_far,
  output logic       hit
);

  logic   gap_xy_next;
  coord_t tmin_xy_next;
  coord_t tmax_xy_next;
  logic   gap_xy;
  coord_t tmin_xy;
  coord_t tmax_xy;
  coord_t near_z;
  coord_t far_z;
  coord_t win_near;
  coord_t win_far;
  logic   gap_z;
  coord_t tmin;
  coord_t tmax;
  logic   hit_next;

  // Merge x and y
  always_comb begin
    gap_xy_next  = (t_near[0] > t_far[1]) || (t_near[1] > t_far[0]);
    tmin_xy_next = (t_near[1] > t_near[0]) ? t_near[1] : t_near[0];
    tmax_xy_next = (t_far[1] < t_far[0]) ? t_far[1] : t_far[0];
  end

  // Stage 4
  always_ff @(posedge clk) begin
    if (load.s4) begin
      gap_xy   <= gap_xy_next;
      tmin_xy  <= tmin_xy_next;
      tmax_xy  <= tmax_xy_next;
      near_z   <= t_near[2];
      far_z    <= t_far[2];
      win_near <= window_near;
      win_far  <= window_far;
    end
  end

  // Merge z, then test against the window with strict compares
  always_comb begin
    gap_z    = (tmin_xy > far_z) || (near_z > tmax_xy);
    tmin     = (near_z > tmin_xy) ? near_z : tmin_xy;
    tmax     = (far_z < tmax_xy) ? far_z : tmax_xy;
    hit_next = !gap_xy && !gap_z && (tmin < win_far) && (win_near < tmax);
  end

  // Stage 5: output register
  always_ff @(posedge clk) begin
    if (load.s5) begin
      hit <= hit_next;
    end
  end

endmodule

>>> rtl/core/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test.
// One ray enters per cycle while in_stall is low, and its hit word passes these stages:
// bound select and subtract, the 33 by 32 bit slab multiply, floor and
// clamp, the x/y merge, then the z merge with the window test. The
// multiplier stage sets the clock. A stall reaches the input in the same
// cycle through a combinational ready chain, and empty stages still fill,
// so a stalled output holds at most five rays inside.
// The box corners are written through cfg_write/cfg_index/cfg_data and
// reset to zero; write them only while no ray is in flight.
module ray_box_slab_test import rbst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  coord_t      origin_x,
  input  coord_t      origin_y,
  input  coord_t      origin_z,
  input  coord_t      inv_dir_x,
  input  coord_t      inv_dir_y,
  input  coord_t      inv_dir_z,
  input  logic [2:0]  axis_signs,
  input  coord_t      window_near,
  input  coord_t      window_far,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit
);

  coord_t     box_low  [NUM_AXES];
  coord_t     box_high [NUM_AXES];
  coord_t     origin   [NUM_AXES];
  coord_t     inv_dir  [NUM_AXES];
  coord_t     t_near   [NUM_AXES];
  coord_t     t_far    [NUM_AXES];
  coord_t     win_near [3];
  coord_t     win_far  [3];
  logic [4:0] valid;
  logic [4:0] ready;
  rbst_load_t load;

  // Box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        box_low[i]  <= '0;
        box_high[i] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BOX_LOW_X:  box_low[0]  <= $signed(cfg_data);
        REG_BOX_LOW_Y:  box_low[1]  <= $signed(cfg_data);
        REG_BOX_LOW_Z:  box_low[2]  <= $signed(cfg_data);
        REG_BOX_HIGH_X: box_high[0] <= $signed(cfg_data);
        REG_BOX_HIGH_Y: box_high[1] <= $signed(cfg_data);
        REG_BOX_HIGH_Z: box_high[2] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Ready chain: a stage loads when empty or when the next stage loads
  always_comb begin
    ready[4] = !valid[4] || !out_stall;
    for (int k = 3; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
    load.s1 = ready[0];
    load.s2 = ready[1];
    load.s3 = ready[2];
    load.s4 = ready[3];
    load.s5 = ready[4];
  end

  assign in_stall  = !ready[0];
  assign out_valid = valid[4];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < 5; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // Carry the window alongside the slab stages
  always_ff @(posedge clk) begin
    if (load.s1) begin
      win_near[0] <= window_near;
      win_far[0]  <= window_far;
    end
    if (load.s2) begin
      win_near[1] <= win_near[0];
      win_far[1]  <= win_far[0];
    end
    if (load.s3) begin
      win_near[2] <= win_near[1];
      win_far[2]  <= win_far[1];
    end
  end

  assign origin[0]  = origin_x;
  assign origin[1]  = origin_y;
  assign origin[2]  = origin_z;
  assign inv_dir[0] = inv_dir_x;
  assign inv_dir[1] = inv_dir_y;
  assign inv_dir[2] = inv_dir_z;

  // One slab unit per axis
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbst_slab u_slab (
      .clk      (clk),
      .load     (load),
      .box_low  (box_low[a]),
      .box_high (box_high[a]),
      .origin   (origin[a]),
      .inv_dir  (inv_dir[a]),
      .sign     (axis_signs[a]),
      .t_near   (t_near[a]),
      .t_far    (t_far[a])
    );
  end

  rbst_merge u_merge (
    .clk         (clk),
    .load        (load),
    .t_near      (t_near),
    .t_far       (t_far),
    .window_near (win_near[2]),
    .window_far  (win_far[2]),
    .hit         (hit)
  );

  // An accepted word always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> valid[0])
    else $error("accepted word lost at pipeline entry");

  // A full pipeline behind a stalled output must push back
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    ((&valid) && out_stall) |-> in_stall)
    else $error("full pipeline did not stall input");

  // A word held at the output keeps every stage behind it full
  a_hold_keeps: assert property (@(posedge clk) disable iff (rst)
    ((&valid) && out_stall) |=> (&valid))
    else $error("stage emptied while output stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (valid == '0))
    else $error("pipeline not empty after reset");

endmodule
